### sv/gdfw_pkg.sv
package gdfw_pkg;

    // Graph sizing.
    localparam int NUM_VERTICES = 16;
    localparam int MAX_DEGREE   = 8;
    localparam int MAX_RESULTS  = 16;

    // Field widths fixed by the item format.
    localparam int VW   = 4;
    localparam int CFGW = 5;
    localparam int STW  = 2;

    // Derived widths.
    localparam int VIW    = $clog2(NUM_VERTICES);
    localparam int CW     = $clog2(MAX_DEGREE + 1);
    localparam int EDEPTH = NUM_VERTICES * MAX_DEGREE;
    localparam int EAW    = $clog2(EDEPTH);
    localparam int SDW    = $clog2(NUM_VERTICES + 1);
    localparam int SIW    = $clog2(NUM_VERTICES);
    localparam int NW     = $clog2(MAX_RESULTS + 1);

    // Configuration register map.
    localparam int PAW              = 3;
    localparam int PDW              = 32;
    localparam int REG_VERTEX_COUNT = 0;
    localparam logic [CFGW-1:0] VCOUNT_RESET = CFGW'(16);

    // Item codes.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_WALK   = 1'b1;
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_WALK = 1'b1;

    typedef enum logic [STW-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_STEP,
        S_EDGE,
        S_FLUSH
    } t_state;

    // One walk stack entry: vertex and index of its next edge to try.
    typedef struct packed {
        logic [VW-1:0] vtx;
        logic [CW-1:0] nxt;
    } t_frame;

    // Controller to datapath.
    typedef struct packed {
        logic in_ready;
        logic add_emit;
        logic walk_bad_emit;
        logic walk_init;
        logic edge_read;
        logic pop;
        logic visit;
        logic flush;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_valid;
        logic is_walk;
        logic walk_bad;
        logic stack_empty;
        logic cap_reached;
        logic edge_avail;
        logic tgt_new;
        logic out_free;
    } t_stat;

endpackage

### sv/gdfw_in_if.sv
interface gdfw_in_if
    import gdfw_pkg::*;
();
    logic          valid;
    logic          ready;
    logic          op;
    logic [VW-1:0] vertex;
    logic [VW-1:0] target;

    modport source (output valid, output op, output vertex, output target, input ready);
    modport sink   (input valid, input op, input vertex, input target, output ready);
endinterface

### sv/gdfw_out_if.sv
interface gdfw_out_if
    import gdfw_pkg::*;
();
    logic           valid;
    logic           ready;
    logic           kind;
    logic [VW-1:0]  visited_vertex;
    logic [STW-1:0] status;
    logic           last;

    modport source (output valid, output kind, output visited_vertex, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input visited_vertex, input status,
                    input last, output ready);
endinterface

### sv/gdfw_ram.sv
module gdfw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port; read data is registered and holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/gdfw_ctrl.sv
module gdfw_ctrl
    import gdfw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_walk && !i_stat.walk_bad) begin
                    n_state = S_STEP;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                if (i_stat.stack_empty || i_stat.cap_reached) begin
                    n_state = S_FLUSH;
                end else if (i_stat.edge_avail) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (!i_stat.tgt_new || i_stat.out_free) begin
                    n_state = S_STEP;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            S_DECODE: begin
                if (!i_stat.is_walk) begin
                    o_cmd.add_emit = i_stat.out_free;
                end else if (i_stat.walk_bad) begin
                    o_cmd.walk_bad_emit = i_stat.out_free;
                end else begin
                    o_cmd.walk_init = 1'b1;
                end
            end
            S_STEP: begin
                if (!i_stat.stack_empty && !i_stat.cap_reached) begin
                    o_cmd.edge_read = i_stat.edge_avail;
                    o_cmd.pop       = !i_stat.edge_avail;
                end
            end
            S_EDGE: begin
                o_cmd.visit = i_stat.tgt_new && i_stat.out_free;
            end
            S_FLUSH: begin
                o_cmd.flush = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

### sv/gdfw_datapath.sv
module gdfw_datapath
    import gdfw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CFGW-1:0] i_vcount,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    gdfw_in_if.sink         i_in,
    gdfw_out_if.source      o_out
);
    logic                 r_op;
    logic [VW-1:0]        r_v;
    logic [VW-1:0]        r_t;
    logic [CW-1:0]        r_counts [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] r_visited;
    t_frame               r_stack [NUM_VERTICES];
    logic [SDW-1:0]       r_depth;
    logic [VW-1:0]        r_hold;
    logic [NW-1:0]        r_n;
    logic                 r_ov;
    logic                 r_kind;
    logic [VW-1:0]        r_ovtx;
    t_status              r_ost;
    logic                 r_last;

    logic [CFGW-1:0]      act_cnt;
    logic                 add_bad;
    logic                 walk_bad;
    logic [SDW-1:0]       depth_m1;
    logic [SIW-1:0]       top_idx;
    t_frame               top;
    logic [VW-1:0]        cnt_vtx;
    logic [CW-1:0]        cnt_sel;
    logic                 list_full;
    logic                 edge_avail;
    logic                 ram_we;
    logic [EAW-1:0]       waddr;
    logic [EAW-1:0]       raddr;
    logic [EAW-1:0]       ram_addr;
    logic [VW-1:0]        w;
    logic                 tgt_new;
    logic                 out_free;
    logic                 emit;
    t_status              add_st;

    // Vertex count in force, capped at the graph size.
    assign act_cnt  = (i_vcount > CFGW'(NUM_VERTICES)) ? CFGW'(NUM_VERTICES) : i_vcount;
    assign add_bad  = (CFGW'(r_v) >= act_cnt) || (CFGW'(r_t) >= act_cnt);
    assign walk_bad = CFGW'(r_v) >= act_cnt;

    // Top of the walk stack.
    assign depth_m1 = r_depth - SDW'(1);
    assign top_idx  = depth_m1[SIW-1:0];
    assign top      = r_stack[top_idx];

    // Edge count lookup: source vertex for add edge, stack top for a walk.
    assign cnt_vtx    = (r_op == OP_WALK) ? top.vtx : r_v;
    assign cnt_sel    = r_counts[cnt_vtx[VIW-1:0]];
    assign list_full  = cnt_sel >= CW'(MAX_DEGREE);
    assign edge_avail = top.nxt < cnt_sel;

    // Edge list memory addressing.
    assign ram_we   = i_cmd.add_emit && !add_bad && !list_full;
    assign waddr    = EAW'(r_v) * EAW'(MAX_DEGREE) + EAW'(cnt_sel);
    assign raddr    = EAW'(top.vtx) * EAW'(MAX_DEGREE) + EAW'(top.nxt);
    assign ram_addr = ram_we ? waddr : raddr;

    gdfw_ram #(
        .WIDTH (VW),
        .DEPTH (EDEPTH)
    ) u_edges (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (i_cmd.edge_read),
        .i_addr  (ram_addr),
        .i_wdata (r_t),
        .o_rdata (w)
    );

    // A target is taken when it is in range and not yet visited.
    assign tgt_new = (CFGW'(w) < act_cnt) && !r_visited[w[VIW-1:0]];

    assign out_free = !r_ov || o_out.ready;
    assign emit     = i_cmd.add_emit || i_cmd.walk_bad_emit || i_cmd.visit || i_cmd.flush;
    assign add_st   = add_bad ? ST_RANGE : (list_full ? ST_FULL : ST_OK);

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_cmd.in_ready) begin
            r_op <= i_in.op;
            r_v  <= i_in.vertex;
            r_t  <= i_in.target;
        end
    end

    // Edge counts, visited marks, stack depth and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VERTICES; i++) begin
                r_counts[i] <= '0;
            end
            r_visited <= '0;
            r_depth   <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (ram_we) begin
                r_counts[r_v[VIW-1:0]] <= cnt_sel + CW'(1);
            end
            if (i_cmd.walk_init) begin
                r_visited <= {{(NUM_VERTICES-1){1'b0}}, 1'b1} << r_v;
                r_depth   <= SDW'(1);
            end
            if (i_cmd.pop || i_cmd.flush) begin
                r_depth <= (i_cmd.pop) ? depth_m1 : '0;
            end
            if (i_cmd.visit) begin
                r_visited[w[VIW-1:0]] <= 1'b1;
                if (r_depth < SDW'(NUM_VERTICES)) begin
                    r_depth <= r_depth + SDW'(1);
                end
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Stack frames, held vertex and result count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_stack[0] <= '{vtx: r_v, nxt: '0};
            r_hold     <= r_v;
            r_n        <= NW'(1);
        end
        if (i_cmd.edge_read) begin
            r_stack[top_idx].nxt <= top.nxt + CW'(1);
        end
        if (i_cmd.visit) begin
            if (r_depth < SDW'(NUM_VERTICES)) begin
                r_stack[r_depth[SIW-1:0]] <= '{vtx: w, nxt: '0};
            end
            r_hold <= w;
            r_n    <= r_n + NW'(1);
        end
    end

    // Output register. A visited vertex is held back until the next one is
    // found or the walk ends, so that the final one can carry last.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_emit) begin
            r_kind <= KIND_ADD;
            r_ovtx <= r_v;
            r_ost  <= add_st;
            r_last <= 1'b1;
        end else if (i_cmd.walk_bad_emit) begin
            r_kind <= KIND_WALK;
            r_ovtx <= r_v;
            r_ost  <= ST_RANGE;
            r_last <= 1'b1;
        end else if (i_cmd.visit || i_cmd.flush) begin
            r_kind <= KIND_WALK;
            r_ovtx <= r_hold;
            r_ost  <= ST_OK;
            r_last <= i_cmd.flush;
        end
    end

    assign i_in.ready           = i_cmd.in_ready;
    assign o_out.valid          = r_ov;
    assign o_out.kind           = r_kind;
    assign o_out.visited_vertex = r_ovtx;
    assign o_out.status         = r_ost;
    assign o_out.last           = r_last;

    // Status to the controller.
    assign o_stat.in_valid    = i_in.valid;
    assign o_stat.is_walk     = (r_op == OP_WALK);
    assign o_stat.walk_bad    = walk_bad;
    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.cap_reached = (r_n == NW'(MAX_RESULTS));
    assign o_stat.edge_avail  = edge_avail;
    assign o_stat.tgt_new     = tgt_new;
    assign o_stat.out_free    = out_free;
endmodule

### sv/graph_depth_first_walk.sv
// Add edge: the beat is captured in IDLE and its result is registered from DECODE.
// Walk: DECODE loads the stack; each stored edge tried is a STEP that issues the registered
// edge-list memory read and an EDGE that checks its target, each stack pop is a STEP, and
// FLUSH emits the last result. The next beat is taken back in IDLE; output stalls hold
// DECODE, EDGE and FLUSH. A walk from an out-of-range vertex finishes like an add edge.
// Synchronous active-low reset clears edge counts, visited marks and stack depth and sets
// vertex_count to 16; the edge-list memory is not cleared and needs no clearing pass.
module graph_depth_first_walk
    import gdfw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    gdfw_in_if.sink        i_in,
    gdfw_out_if.source     o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready
);
    logic [CFGW-1:0] r_vcount;
    logic            reg_sel;
    t_cmd            cmd;
    t_stat           stat;

    // Register decode: word index from the byte address.
    assign reg_sel = (paddr[PAW-1:2] == 1'(REG_VERTEX_COUNT));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDW'(r_vcount) : '0;

    // Vertex count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_vcount <= pwdata[CFGW-1:0];
        end
    end

    gdfw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gdfw_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vcount (r_vcount),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_in     (i_in),
        .o_out    (o_out)
    );
endmodule

### bench/gdfw_walk_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the graph walker.
// Keeps its own copy of the edge lists and the vertex count and compares every result beat.
module gdfw_walk_checker
    import gdfw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    gdfw_in_if             i_items,
    gdfw_out_if            i_results,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic [PAW-1:0] i_paddr,
    input  logic [PDW-1:0] i_pwdata,
    input  logic           i_pready,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked
);

    typedef struct packed {
        logic          kind;
        logic [VW-1:0] vtx;
        t_status       status;
        logic          last;
    } t_graph_result;

    // Shadow copy of the graph and the register.
    logic [CFGW-1:0] vertex_limit;
    int              edge_count [NUM_VERTICES];
    logic [VW-1:0]   edge_target [NUM_VERTICES][MAX_DEGREE];
    t_graph_result   expected_results [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [VW-1:0] got,
                               input logic [VW-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: expected %0d, got %0d",
                                      o_checked, name, want, got));
        end
    endtask

    function automatic t_graph_result make_result(input logic kind, input logic [VW-1:0] v,
                                                  input t_status st, input logic fin);
        t_graph_result r;
        r.kind   = kind;
        r.vtx    = v;
        r.status = st;
        r.last   = fin;
        return r;
    endfunction

    // Appends one result to the tail of the expected queue.
    task automatic queue_expected(input t_graph_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // Works out the results of one item and updates the shadow edge lists.
    task automatic predict_item(input logic op, input logic [VW-1:0] v,
                                input logic [VW-1:0] t);
        int                      lim;
        int                      depth;
        int                      u;
        int                      w;
        logic [NUM_VERTICES-1:0] seen;
        int                      frame_vtx [NUM_VERTICES];
        int                      frame_next [NUM_VERTICES];
        t_graph_result           preorder [$];
        lim = (int'(vertex_limit) > NUM_VERTICES) ? NUM_VERTICES : int'(vertex_limit);
        if (op == OP_ADD) begin
            if (int'(v) >= lim || int'(t) >= lim) begin
                queue_expected(make_result(KIND_ADD, v, ST_RANGE, 1'b1));
            end else if (edge_count[v] >= MAX_DEGREE) begin
                queue_expected(make_result(KIND_ADD, v, ST_FULL, 1'b1));
            end else begin
                edge_target[v][edge_count[v]] = t;
                edge_count[v]++;
                queue_expected(make_result(KIND_ADD, v, ST_OK, 1'b1));
            end
        end else if (int'(v) >= lim) begin
            queue_expected(make_result(KIND_WALK, v, ST_RANGE, 1'b1));
        end else begin
            // Depth-first preorder with an explicit stack of (vertex, next edge) frames.
            seen          = '0;
            seen[v]       = 1'b1;
            frame_vtx[0]  = v;
            frame_next[0] = 0;
            depth         = 1;
            preorder.insert(preorder.size(), make_result(KIND_WALK, v, ST_OK, 1'b0));
            while (depth > 0 && preorder.size() < MAX_RESULTS) begin
                u = frame_vtx[depth-1];
                if (frame_next[depth-1] < edge_count[u]) begin
                    w = edge_target[u][frame_next[depth-1]];
                    frame_next[depth-1]++;
                    // Targets beyond the current count and revisits are skipped.
                    if (w < lim && !seen[w]) begin
                        seen[w] = 1'b1;
                        preorder.insert(preorder.size(),
                                        make_result(KIND_WALK, VW'(w), ST_OK, 1'b0));
                        if (depth < NUM_VERTICES) begin
                            frame_vtx[depth]  = w;
                            frame_next[depth] = 0;
                            depth++;
                        end
                    end
                end else begin
                    depth--;
                end
            end
            preorder[preorder.size()-1].last = 1'b1;
            foreach (preorder[i]) begin
                queue_expected(preorder[i]);
            end
        end
    endtask

    // Register writes, item beats and result beats, all seen at the rising edge.
    always @(posedge i_clk) begin
        t_graph_result want;
        if (!i_rst_n) begin
            vertex_limit = VCOUNT_RESET;
            foreach (edge_count[i]) begin
                edge_count[i] = 0;
            end
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == PAW'(REG_VERTEX_COUNT * 4)) begin
                vertex_limit = i_pwdata[CFGW-1:0];
            end
            if (i_items.valid && i_items.ready) begin
                predict_item(i_items.op, i_items.vertex, i_items.target);
            end
            if (i_results.valid && i_results.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d vertex %0d with nothing pending",
                                              i_results.kind, i_results.visited_vertex));
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", VW'(i_results.kind), VW'(want.kind));
                    check_field("visited_vertex", i_results.visited_vertex, want.vtx);
                    check_field("status", VW'(i_results.status), VW'(want.status));
                    check_field("last", VW'(i_results.last), VW'(want.last));
                    o_checked++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gdfw_pkg::*;

    localparam int IDLE_CYCLES  = 16;
    localparam int PHASE_ITEMS  = 17;
    localparam int PHASE_COUNT  = 5;

    logic           i_clk;
    logic           i_rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic           pready;

    int   fail_count;
    int   pending;
    int   checked;
    int   edges_offered;
    int   walks_offered;
    int   settings_used;
    logic tx_eager;
    logic rx_eager;

    gdfw_in_if  in_ch ();
    gdfw_out_if out_ch ();

    graph_depth_first_walk i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gdfw_walk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_items      (in_ch),
        .i_results    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Offers one item after a random gap and holds it until the beat is taken.
    task automatic offer_item(input logic op, input logic [VW-1:0] v, input logic [VW-1:0] t);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.op     = op;
        in_ch.vertex = v;
        in_ch.target = t;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (op == OP_ADD) begin
            edges_offered++;
        end else begin
            walks_offered++;
        end
    endtask

    // Lets every pending result drain and the walker settle, then writes the vertex count.
    task automatic set_vertex_count(input int value);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PAW'(REG_VERTEX_COUNT * 4);
        pwdata  = PDW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        settings_used++;
    endtask

    // Result side: random stall before every beat, none while rx_eager is set.
    initial begin : result_drain
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = rx_eager ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int          phase_limit [PHASE_COUNT];
        int          lim;
        logic        op;
        logic [VW-1:0] v;
        logic [VW-1:0] t;
        logic        in_range;
        in_ch.valid   = 1'b0;
        in_ch.op      = OP_ADD;
        in_ch.vertex  = '0;
        in_ch.target  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_eager      = 1'b0;
        rx_eager      = 1'b0;
        edges_offered = 0;
        walks_offered = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk on the empty graph gives only the start vertex.
        offer_item(OP_WALK, 4'd0, 4'd0);
        // Small graph with a back edge, a self loop and the highest vertex.
        offer_item(OP_ADD, 4'd0, 4'd1);
        offer_item(OP_ADD, 4'd0, 4'd2);
        offer_item(OP_ADD, 4'd1, 4'd3);
        offer_item(OP_ADD, 4'd3, 4'd0);
        offer_item(OP_ADD, 4'd2, 4'd2);
        offer_item(OP_ADD, 4'd1, 4'd15);
        offer_item(OP_ADD, 4'd15, 4'd0);
        offer_item(OP_WALK, 4'd0, 4'd9);

        // Four vertices: out-of-range source, target and start, then stale edges skipped.
        set_vertex_count(4);
        offer_item(OP_ADD, 4'd5, 4'd1);
        offer_item(OP_ADD, 4'd1, 4'd9);
        offer_item(OP_WALK, 4'd9, 4'd0);
        offer_item(OP_WALK, 4'd0, 4'd0);
        // Fill the list of vertex 2; the next edge is dropped.
        for (int i = 0; i < MAX_DEGREE - 1; i++) begin
            offer_item(OP_ADD, 4'd2, VW'(i % 4));
        end
        offer_item(OP_ADD, 4'd2, 4'd3);
        offer_item(OP_WALK, 4'd2, 4'd0);

        // A count of zero rejects everything.
        set_vertex_count(0);
        offer_item(OP_ADD, 4'd0, 4'd0);
        offer_item(OP_WALK, 4'd0, 4'd0);

        // A count above the vertex total acts as the full graph.
        set_vertex_count(31);
        offer_item(OP_WALK, 4'd15, 4'd0);

        // Random phases, each under its own vertex count.
        phase_limit = '{16, 1, 0, 31, 0};
        phase_limit[2] = $urandom_range(2, 15);
        phase_limit[4] = $urandom_range(5, 16);
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_vertex_count(phase_limit[p]);
            lim      = (phase_limit[p] > NUM_VERTICES) ? NUM_VERTICES : phase_limit[p];
            tx_eager = (p == 0) || ($urandom_range(0, 3) == 0);
            rx_eager = (p == 0) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op       = ($urandom_range(0, 99) < 65) ? OP_ADD : OP_WALK;
                in_range = ($urandom_range(0, 99) < 85);
                v        = in_range ? VW'($urandom_range(0, lim - 1)) : VW'($urandom_range(0, 15));
                t        = in_range ? VW'($urandom_range(0, lim - 1)) : VW'($urandom_range(0, 15));
                offer_item(op, v, t);
            end
        end
        in_ch.valid = 1'b0;

        // Let the last results drain, then give the verdict.
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
        $display("Covered %0d add-edge and %0d walk items under %0d vertex-count settings.",
                 edges_offered, walks_offered, settings_used);
        $display("Compared %0d result beats; %0d mismatches.", checked, fail_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5000000;
        $display("Timeout with %0d results still pending.", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
